/* rtl/core/pha_pkg.sv */
// ----------------------------------------------------------------------------
// pha_pkg: shared types and constants of the pixel histogram accumulator
// Transaction payloads, command codes and the register map.
// ----------------------------------------------------------------------------
package pha_pkg;

  localparam int unsigned VALUE_W     = 8;
  localparam int unsigned BIN_COUNT_W = 20;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;

  // Word index of the only register.
  localparam logic REG_MAX_GREY_LEVEL = 1'b0;
  localparam logic [VALUE_W-1:0] MAX_GREY_LEVEL_RESET = 8'd255;

  typedef enum logic {
    CMD_ACCUMULATE = 1'b0,
    CMD_READ       = 1'b1
  } pha_cmd_e;

  typedef struct packed {
    pha_cmd_e           cmd;
    logic [VALUE_W-1:0] value;
  } pha_in_t;

  typedef struct packed {
    logic [BIN_COUNT_W-1:0] bin_count;
    logic                   out_of_range;
  } pha_out_t;

endpackage

/* rtl/core/pha_cfg_regs.sv */
// ----------------------------------------------------------------------------
// pha_cfg_regs: configuration register file
// APB slave holding the highest valid grey level.
// ----------------------------------------------------------------------------
module pha_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pha_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [pha_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [pha_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic [pha_pkg::VALUE_W-1:0]      max_grey_o
);
  import pha_pkg::*;

  logic [VALUE_W-1:0] max_grey_q;
  logic               reg_sel;
  logic               wr_en;

  // The low two address bits select a byte lane and are ignored.
  assign reg_sel = (paddr[2] == REG_MAX_GREY_LEVEL);
  assign wr_en   = psel && penable && pwrite && reg_sel;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_grey_q <= MAX_GREY_LEVEL_RESET;
    end else if (wr_en) begin
      max_grey_q <= pwdata[VALUE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = APB_DATA_W'(max_grey_q);
    end
  end

  assign max_grey_o = max_grey_q;

endmodule

/* rtl/core/pha_bin_store.sv */
// ----------------------------------------------------------------------------
// pha_bin_store: bin counter memory
// One write port and one registered read port, with a clearing pass after
// reset that zeroes one entry per cycle.
// ----------------------------------------------------------------------------
module pha_bin_store #(
  parameter int unsigned NUM_BINS   = 256,
  parameter int unsigned COUNT_BITS = 20,
  parameter int unsigned IDX_W      = $clog2(NUM_BINS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic [IDX_W-1:0]      rd_addr_i,
  output logic [COUNT_BITS-1:0] rd_data_o,
  input  logic                  wr_en_i,
  input  logic [IDX_W-1:0]      wr_addr_i,
  input  logic [COUNT_BITS-1:0] wr_data_i,
  output logic                  busy_o
);

  logic [COUNT_BITS-1:0] mem_q [NUM_BINS];
  logic [COUNT_BITS-1:0] rd_data_q;
  logic                  clr_q;
  logic [IDX_W-1:0]      clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      if (clr_addr_q == IDX_W'(NUM_BINS - 1)) begin
        clr_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_q;

endmodule

/* rtl/core/pha_update.sv */
// ----------------------------------------------------------------------------
// pha_update: read-modify-write pipeline
// Issues the bin read, forwards the last write, saturates the increment,
// writes back and holds the result in an output register.
// ----------------------------------------------------------------------------
module pha_update #(
  parameter int unsigned NUM_BINS   = 256,
  parameter int unsigned COUNT_BITS = 20,
  parameter int unsigned IDX_W      = $clog2(NUM_BINS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  pha_pkg::pha_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output pha_pkg::pha_out_t           out_data_o,
  input  logic [pha_pkg::VALUE_W-1:0] max_grey_i,
  input  logic                        busy_i,
  output logic                        rd_en_o,
  output logic [IDX_W-1:0]            rd_addr_o,
  input  logic [COUNT_BITS-1:0]       rd_data_i,
  output logic                        wr_en_o,
  output logic [IDX_W-1:0]            wr_addr_o,
  output logic [COUNT_BITS-1:0]       wr_data_o
);
  import pha_pkg::*;

  logic                  s1_valid_q;
  logic                  s1_acc_q;
  logic                  s1_oor_q;
  logic [IDX_W-1:0]      s1_idx_q;
  logic                  fwd_valid_q;
  logic [IDX_W-1:0]      fwd_idx_q;
  logic [COUNT_BITS-1:0] fwd_data_q;
  logic                  out_valid_q;
  pha_out_t              out_q;

  logic                  s1_adv;
  logic                  accept;
  logic [31:0]           value_ext;
  logic                  in_oor;
  logic [COUNT_BITS-1:0] cur_count;
  logic [COUNT_BITS-1:0] inc_count;
  logic [COUNT_BITS-1:0] res_count;
  logic [31:0]           res_ext;
  logic                  do_write;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !busy_i && (!s1_valid_q || s1_adv);
  assign accept     = in_valid_i && in_ready_o;

  assign value_ext = 32'(in_data_i.value);
  assign in_oor    = (in_data_i.value > max_grey_i) || (value_ext >= NUM_BINS);

  assign rd_en_o   = accept;
  assign rd_addr_o = value_ext[IDX_W-1:0];

  // The write of the previous transaction lands on the same edge as this
  // read, so the memory returns the older count; take it from the bypass.
  assign cur_count = (fwd_valid_q && (fwd_idx_q == s1_idx_q)) ? fwd_data_q : rd_data_i;
  assign inc_count = (&cur_count) ? cur_count : cur_count + 1'b1;

  always_comb begin
    res_count = cur_count;
    if (s1_oor_q) begin
      res_count = '0;
    end else if (s1_acc_q) begin
      res_count = inc_count;
    end
  end

  assign res_ext   = 32'(res_count);
  assign do_write  = s1_adv && s1_acc_q && !s1_oor_q;
  assign wr_en_o   = do_write;
  assign wr_addr_o = s1_idx_q;
  assign wr_data_o = inc_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (busy_i) begin
        fwd_valid_q <= 1'b0;
      end else if (do_write) begin
        fwd_valid_q <= 1'b1;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_acc_q <= (in_data_i.cmd == CMD_ACCUMULATE);
      s1_oor_q <= in_oor;
      s1_idx_q <= value_ext[IDX_W-1:0];
    end
    if (do_write) begin
      fwd_idx_q  <= s1_idx_q;
      fwd_data_q <= inc_count;
    end
    if (s1_adv) begin
      out_q.bin_count    <= res_ext[BIN_COUNT_W-1:0];
      out_q.out_of_range <= s1_oor_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/core/pixel_histogram_accumulator.sv */
// ----------------------------------------------------------------------------
// pixel_histogram_accumulator: grey-level histogram with saturating bins
// Counts pixel values into one counter per grey level and reads bins back.
// ----------------------------------------------------------------------------
// The block sustains one transaction per clock cycle while results are taken:
// each one reads its bin from the counter memory at acceptance, updates it in
// the update stage and writes it back, while a bypass register supplies the
// count that the previous transaction is writing on the same edge. A result
// passes from the update stage into the output register. While that result
// waits, one more transaction is taken into the update stage, and in_ready_o
// then stays low until the waiting result is taken. After reset the memory is
// cleared by a pass over all NUM_BINS entries, during which in_ready_o stays
// low; configuration writes are taken during that pass.
module pixel_histogram_accumulator #(
  parameter int unsigned NUM_BINS   = 256,
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  pha_pkg::pha_in_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output pha_pkg::pha_out_t                out_data_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pha_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [pha_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [pha_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import pha_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_BINS);

  logic [VALUE_W-1:0]    max_grey;
  logic                  busy;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [COUNT_BITS-1:0] rd_data;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [COUNT_BITS-1:0] wr_data;

  pha_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .max_grey_o (max_grey)
  );

  pha_bin_store #(
    .NUM_BINS   (NUM_BINS),
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .busy_o    (busy)
  );

  pha_update #(
    .NUM_BINS   (NUM_BINS),
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      (IDX_W)
  ) u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .max_grey_i  (max_grey),
    .busy_i      (busy),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

endmodule
